FILE: design/jpp_pkg.sv
// package: shared constants, types and helpers of the json pretty printer
`timescale 1ns / 1ps
`default_nettype none
package jpp_pkg;

  localparam int DEPTH_W       = 5;
  localparam int SPC_W         = DEPTH_W + 1;
  localparam int MAX_DEPTH_DEF = 31;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD,
    S_NL,
    S_SPACE,
    S_TAIL
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SEL_BYTE,
    SEL_NL,
    SEL_SPACE
  } out_sel_e;

  typedef struct packed {
    logic lead;
    logic brk;
    logic tail;
  } plan_t;

  typedef struct packed {
    logic     accept;
    logic     load;
    out_sel_e sel;
    logic     last;
    logic     dec;
  } cmd_t;

  typedef struct packed {
    plan_t in_plan;
    plan_t plan;
    logic  spc_zero;
    logic  spc_one;
    logic  out_free;
  } status_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage
`default_nettype wire

FILE: design/jpp_stream_if.sv
// interfaces: input and output request channels of the json pretty printer
`timescale 1ns / 1ps
`default_nettype none
interface jpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       starts_message;

  modport source (output valid, output text_byte, output starts_message, input ready);
  modport sink (input valid, input text_byte, input starts_message, output ready);
endinterface

interface jpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: design/jpp_ctrl.sv
// controller: state machine that sequences the result bytes of one request
`timescale 1ns / 1ps
`default_nettype none
module jpp_ctrl
  import jpp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_plan.lead) begin
            state_d = S_LEAD;
          end else if (status_i.in_plan.brk) begin
            state_d = S_NL;
          end
        end
      end
      S_LEAD: begin
        if (status_i.out_free) begin
          state_d = status_i.plan.brk ? S_NL : S_IDLE;
        end
      end
      S_NL: begin
        if (status_i.out_free) begin
          if (!status_i.spc_zero) begin
            state_d = S_SPACE;
          end else begin
            state_d = status_i.plan.tail ? S_TAIL : S_IDLE;
          end
        end
      end
      S_SPACE: begin
        if (status_i.out_free && status_i.spc_one) begin
          state_d = status_i.plan.tail ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o.accept  = in_valid_i && (state_q == S_IDLE);
    cmd_o.load    = 1'b0;
    cmd_o.sel     = SEL_BYTE;
    cmd_o.last    = 1'b0;
    cmd_o.dec     = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = 1'b0;
      end
      S_LEAD: begin
        cmd_o.load = status_i.out_free;
        cmd_o.last = !status_i.plan.brk;
      end
      S_NL: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = SEL_NL;
        cmd_o.last = status_i.spc_zero && !status_i.plan.tail;
      end
      S_SPACE: begin
        cmd_o.load = status_i.out_free;
        cmd_o.sel  = SEL_SPACE;
        cmd_o.dec  = status_i.out_free;
        cmd_o.last = status_i.spc_one && !status_i.plan.tail;
      end
      S_TAIL: begin
        cmd_o.load = status_i.out_free;
        cmd_o.last = 1'b1;
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

  a_space_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPACE) |-> !status_i.spc_zero)
    else $error("space run entered with empty count");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("last byte loaded but controller not idle");

  a_tail_planned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |-> status_i.plan.tail)
    else $error("trailing bracket without plan");

endmodule
`default_nettype wire

FILE: design/jpp_dp.sv
// datapath: parse state, request decode, space counter and output register
`timescale 1ns / 1ps
`default_nettype none
module jpp_dp
  import jpp_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output status_t         status_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       starts_message_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  localparam logic [DEPTH_W-1:0] MaxD = DEPTH_W'(MAX_DEPTH);

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               instr_q, instr_d;
  logic               bslash_q, bslash_d;
  logic               lstart_q, lstart_d;
  logic [7:0]         byte_q;
  plan_t              plan_q, plan_d;
  logic [SPC_W-1:0]   spc_q, spc_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               out_last_q;

  logic [DEPTH_W-1:0] cur_depth;
  logic               cur_instr, cur_bslash, cur_lstart;
  logic               is_open, is_close, is_comma, is_other, blank;

  // decode against state as seen by this request
  always_comb begin
    cur_depth  = starts_message_i ? '0 : depth_q;
    cur_instr  = starts_message_i ? 1'b0 : instr_q;
    cur_bslash = starts_message_i ? 1'b0 : bslash_q;
    cur_lstart = starts_message_i ? 1'b1 : lstart_q;

    is_open  = (text_byte_i == CH_LBRACE) || (text_byte_i == CH_LBRACK);
    is_close = (text_byte_i == CH_RBRACE) || (text_byte_i == CH_RBRACK);
    is_comma = (text_byte_i == CH_COMMA);
    is_other = !is_open && !is_close && !is_comma;
    blank    = is_blank(text_byte_i);

    plan_d.lead = is_open || is_comma || (is_close && cur_instr) ||
                  (is_other && (!cur_lstart || !blank));
    plan_d.brk  = !cur_instr && !is_other;
    plan_d.tail = !cur_instr && is_close;

    depth_d = cur_depth;
    if (!cur_instr && is_open && (cur_depth < MaxD)) begin
      depth_d = cur_depth + DEPTH_W'(1);
    end else if (!cur_instr && is_close && (cur_depth != '0)) begin
      depth_d = cur_depth - DEPTH_W'(1);
    end

    lstart_d = cur_lstart;
    if (plan_d.brk) begin
      lstart_d = 1'b1;
    end else if (is_other && cur_lstart && !blank) begin
      lstart_d = 1'b0;
    end

    instr_d  = cur_instr;
    bslash_d = 1'b0;
    if (text_byte_i == CH_BSLASH) begin
      bslash_d = !cur_bslash;
    end else if ((text_byte_i == CH_QUOTE) && !cur_bslash) begin
      instr_d = !cur_instr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      instr_q  <= 1'b0;
      bslash_q <= 1'b0;
      lstart_q <= 1'b1;
      plan_q   <= '0;
    end else if (cmd_i.accept) begin
      depth_q  <= depth_d;
      instr_q  <= instr_d;
      bslash_q <= bslash_d;
      lstart_q <= lstart_d;
      plan_q   <= plan_d;
    end
  end

  // space counter
  always_comb begin
    spc_d = spc_q;
    if (cmd_i.accept) begin
      spc_d = {depth_d, 1'b0};
    end else if (cmd_i.dec) begin
      spc_d = spc_q - SPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= '0;
    end else begin
      spc_q <= spc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= text_byte_i;
    end
  end

  // output register
  always_comb begin
    case (cmd_i.sel)
      SEL_BYTE:  out_byte_d = byte_q;
      SEL_NL:    out_byte_d = CH_NL;
      SEL_SPACE: out_byte_d = CH_SPACE;
      default:   out_byte_d = byte_q;
    endcase
    out_valid_d = cmd_i.load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    status_o.in_plan  = plan_d;
    status_o.plan     = plan_q;
    status_o.spc_zero = (spc_q == '0);
    status_o.spc_one  = (spc_q == SPC_W'(1));
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MaxD)
    else $error("nesting depth beyond limit");

  a_spc_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (spc_q[0] == 1'b0))
    else $error("indent run length not even");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable(out_byte_q) && $stable(out_last_q)))
    else $error("stalled output request changed");

endmodule
`default_nettype wire

FILE: design/json_pretty_print_stream.sv
// The request byte and its plan are registered on acceptance, then each result
// byte passes the single output register. Throughput: one result byte per cycle
// while output is not stalled; input waits while result bytes load, a dropped
// blank loads none, and the next request may enter while the last byte waits.
// Reset: asynchronous active low; depth 0, string and escape flags clear,
// line start set, output empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module json_pretty_print_stream
  import jpp_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jpp_in_if.sink     in_i,
  jpp_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  jpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jpp_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .text_byte_i      (in_i.text_byte),
    .starts_message_i (in_i.starts_message),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_byte_o       (out_o.out_byte),
    .out_last_o       (out_o.last_of_run)
  );

  assign in_i.ready = in_ready;

endmodule
`default_nettype wire
